/* design/fle_pkg.sv */
// ----------------------------------------------------------------------------
// fle_pkg: shared types and constants for the flag/length frame extractor
// Frame word layout, status and register index codes, queue sizing.
// ----------------------------------------------------------------------------
package fle_pkg;

  localparam logic [15:0] MAX_LEN_RESET   = 16'd1037;
  localparam logic [15:0] SHORT_FRAME_LEN = 16'd4;
  localparam logic [15:0] MIN_LONG_LEN    = 16'd5;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_START_FLAG = 2'd0,
    CFG_END_FLAG   = 2'd1,
    CFG_MAX_LEN    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  start_flag;
    logic [7:0]  end_flag;
    logic [15:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [15:0] frame_index;
    logic        frame_last;
    status_t     frame_status;
  } frame_word_t;

endpackage

/* design/fle_front.sv */
// ----------------------------------------------------------------------------
// fle_front: byte classifier
// Tracks hunt/frame state, position and declared length; emits one frame
// word per accepted frame byte.
// ----------------------------------------------------------------------------
module fle_front import fle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic [7:0]  rx_byte,
  input  logic        q_full,
  output logic        push,
  output frame_word_t push_word
);

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic        accept;
  logic        emit;

  assign accept = in_valid && !q_full;
  assign push   = accept && emit;

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    emit         = 1'b1;
    push_word.frame_byte   = rx_byte;
    push_word.frame_index  = pos_r;
    push_word.frame_last   = 1'b0;
    push_word.frame_status = ST_PROGRESS;
    if (!in_frame_r) begin
      push_word.frame_index = '0;
      if (rx_byte == cfg.start_flag) begin
        in_frame_nxt = 1'b1;
        pos_nxt      = 16'd1;
        len_nxt      = '0;
      end else begin
        emit = 1'b0;
      end
    end else if (pos_r == 16'd1) begin
      len_nxt = {rx_byte, 8'd0};
      pos_nxt = 16'd2;
    end else if (pos_r == 16'd2) begin
      len_nxt = {len_r[15:8], rx_byte};
      pos_nxt = 16'd3;
    end else if (pos_r == SHORT_FRAME_LEN - 16'd1) begin
      if (rx_byte == cfg.end_flag) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        push_word.frame_last   = 1'b1;
        push_word.frame_status = ST_GOOD;
      end else if (len_r > cfg.max_frame_len || len_r < MIN_LONG_LEN) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        push_word.frame_last   = 1'b1;
        push_word.frame_status = ST_BAD;
      end else begin
        pos_nxt = pos_r + 16'd1;
      end
    end else if (({1'b0, pos_r} + 17'd1) >= {1'b0, len_r}) begin
      in_frame_nxt = 1'b0;
      pos_nxt      = '0;
      push_word.frame_last   = 1'b1;
      push_word.frame_status = (rx_byte == cfg.end_flag) ? ST_GOOD : ST_BAD;
    end else begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      len_r      <= '0;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

/* design/fle_queue.sv */
// ----------------------------------------------------------------------------
// fle_queue: short word queue
// Decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
module fle_queue import fle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_word_t push_word,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output frame_word_t head_word
);

  frame_word_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]      wr_ptr_r;
  logic [Q_AW-1:0]      rd_ptr_r;
  logic [Q_AW:0]        cnt_r;

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* design/fle_back.sv */
// ----------------------------------------------------------------------------
// fle_back: output stage
// Registered result word, refilled from the queue whenever it frees up.
// ----------------------------------------------------------------------------
module fle_back import fle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  frame_word_t head_word,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output frame_word_t out_word
);

  logic        out_valid_r;
  frame_word_t out_word_r;

  assign pop       = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= head_word;
    end
  end

endmodule

/* design/flag_length_frame_extractor_unit.sv */
// ----------------------------------------------------------------------------
// flag_length_frame_extractor_unit: start/end flag, length-prefixed deframer
// An accepted frame byte reaches out_valid through the queue write, then the
// output register. Throughput: 1 byte per cycle; in_stall rises only
// when the 4-word queue fills behind a stalled output.
// Synchronous active-low reset: hunting state, empty queue, registers to
// their defaults (flags 0, max length 1037).
// ----------------------------------------------------------------------------
module flag_length_frame_extractor_unit import fle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic [15:0] out_frame_index,
  output logic        out_frame_last,
  output logic [1:0]  out_frame_status
);

  cfg_t        cfg_r;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  frame_word_t push_word;
  frame_word_t head_word;
  frame_word_t out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_flag    <= '0;
      cfg_r.end_flag      <= '0;
      cfg_r.max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_FLAG: cfg_r.start_flag    <= cfg_wr_data[7:0];
        CFG_END_FLAG:   cfg_r.end_flag      <= cfg_wr_data[7:0];
        CFG_MAX_LEN:    cfg_r.max_frame_len <= cfg_wr_data;
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_stall = q_full;

  fle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .rx_byte   (in_rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  fle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_word (head_word)
  );

  fle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_word (head_word),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_frame_byte   = out_word.frame_byte;
  assign out_frame_index  = out_word.frame_index;
  assign out_frame_last   = out_word.frame_last;
  assign out_frame_status = out_word.frame_status;

endmodule

/* design/fle_checker.sv */
// ----------------------------------------------------------------------------
// fle_checker: port-level checks for the frame extractor
// Bound to the top level; watches the result channel over time.
// ----------------------------------------------------------------------------
module fle_checker import fle_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_frame_byte,
  input logic [15:0] out_frame_index,
  input logic        out_frame_last,
  input logic [1:0]  out_frame_status
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_frame_index) && $stable(out_frame_last) &&
      $stable(out_frame_status))
    else $error("stalled output word changed");

  // last mark and closing status go together
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_last == (out_frame_status != ST_PROGRESS)))
    else $error("last mark and status disagree");

  // no frame closes before index 3
  a_close_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_frame_index >= 16'd3)
    else $error("frame closed before index 3");

  // taken closing word is followed by a new frame start or nothing
  a_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_last ##1 out_valid |->
      out_frame_index == 16'd0)
    else $error("word after frame close is not index 0");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind flag_length_frame_extractor_unit fle_checker u_fle_checker (.*);

/* sim/fle_frame_checker.sv */
// ----------------------------------------------------------------------------
// fle_frame_checker: frame word checker for the flag/length frame extractor
// Watches the register port and both channels and predicts one frame word
// for every accepted received byte that belongs to a frame. It compares each accepted output word
// field by field with the oldest prediction. Counts failures for the top.
// ----------------------------------------------------------------------------
module fle_frame_checker import fle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_frame_byte,
  input  logic [15:0] out_frame_index,
  input  logic        out_frame_last,
  input  logic [1:0]  out_frame_status,
  output int          errors,
  output int          words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  logic [7:0]  start_flag_r = 8'h00;
  logic [7:0]  end_flag_r   = 8'h00;
  logic [15:0] max_len_r    = MAX_LEN_RESET;

  logic        rx_in_frame = 1'b0;
  logic [15:0] rx_pos      = 16'd0;
  logic [15:0] rx_len      = 16'd0;

  frame_word_t expected_words[$];

  initial begin
    errors    = 0;
    words_due = 0;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) begin
      $display("%0t ns: frame word mismatch: %s", $time, what);
    end
    errors++;
  endtask

  task automatic close_frame();
    rx_in_frame = 1'b0;
    rx_pos      = 16'd0;
  endtask

  // one received byte: update the deframer state, queue the word it causes
  task automatic predict_frame_word(input logic [7:0] b);
    frame_word_t w;
    logic        emit;
    emit           = 1'b1;
    w.frame_byte   = b;
    w.frame_index  = rx_pos;
    w.frame_last   = 1'b0;
    w.frame_status = ST_PROGRESS;
    if (!rx_in_frame) begin
      if (b != start_flag_r) begin
        emit = 1'b0;
      end else begin
        rx_in_frame   = 1'b1;
        rx_pos        = 16'd1;
        rx_len        = 16'd0;
        w.frame_index = 16'd0;
      end
    end else if (rx_pos == 16'd1) begin
      rx_len = {b, 8'h00};
      rx_pos = 16'd2;
    end else if (rx_pos == 16'd2) begin
      rx_len[7:0] = b;
      rx_pos      = 16'd3;
    end else if (rx_pos == SHORT_FRAME_LEN - 16'd1) begin
      if (b == end_flag_r) begin
        close_frame();
        w.frame_last   = 1'b1;
        w.frame_status = ST_GOOD;
      end else if (rx_len > max_len_r || rx_len < MIN_LONG_LEN) begin
        close_frame();
        w.frame_last   = 1'b1;
        w.frame_status = ST_BAD;
      end else begin
        rx_pos = rx_pos + 16'd1;
      end
    end else if ({1'b0, rx_pos} + 17'd1 >= {1'b0, rx_len}) begin
      close_frame();
      w.frame_last   = 1'b1;
      w.frame_status = (b == end_flag_r) ? ST_GOOD : ST_BAD;
    end else begin
      rx_pos = rx_pos + 16'd1;
    end
    if (emit) begin
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  task automatic check_frame_word();
    frame_word_t w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte %02h index %0d",
                                out_frame_byte, out_frame_index));
    end else begin
      w = expected_words[0];
      expected_words.delete(0);
      if (out_frame_byte !== w.frame_byte) begin
        report_mismatch($sformatf("index %0d: byte %02h, want %02h",
                                  w.frame_index, out_frame_byte, w.frame_byte));
      end
      if (out_frame_index !== w.frame_index) begin
        report_mismatch($sformatf("index %0d, want %0d", out_frame_index,
                                  w.frame_index));
      end
      if (out_frame_last !== w.frame_last) begin
        report_mismatch($sformatf("index %0d: last %b, want %b", w.frame_index,
                                  out_frame_last, w.frame_last));
      end
      if (out_frame_status !== w.frame_status) begin
        report_mismatch($sformatf("index %0d: status %0d, want %0d",
                                  w.frame_index, out_frame_status,
                                  w.frame_status));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r = 8'h00;
      end_flag_r   = 8'h00;
      max_len_r    = MAX_LEN_RESET;
      close_frame();
      rx_len       = 16'd0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_FLAG: start_flag_r = cfg_wr_data[7:0];
          CFG_END_FLAG:   end_flag_r   = cfg_wr_data[7:0];
          CFG_MAX_LEN:    max_len_r    = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_frame_word(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        check_frame_word();
      end
    end
    words_due <= expected_words.size();
  end

endmodule

/* sim/tb_flag_length_frame_extractor_unit.sv */
// ----------------------------------------------------------------------------
// tb_flag_length_frame_extractor_unit: testbench for the frame extractor
// Directed frames for the flag, length and end-flag corner cases, then
// random frame streams under several register settings and idle/stall
// mixes. Checking is done by fle_frame_checker beside the block.
// ----------------------------------------------------------------------------
module tb_flag_length_frame_extractor_unit import fle_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED_IDX  = 2'd3;
  localparam int         NUM_PHASES      = 8;
  localparam int         PHASE_WORDS     = 165;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         MAX_TEST_LEN    = 40;
  localparam int         CYCLE_LIMIT     = 250000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_index   = 2'd0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  out_frame_byte;
  logic [15:0] out_frame_index;
  logic        out_frame_last;
  logic [1:0]  out_frame_status;

  int errors;
  int words_due;
  int idle_pct  = 0;
  int stall_pct = 0;
  int phase_words;
  int cycle_count = 0;

  logic [7:0]  cur_start = 8'h00;
  logic [7:0]  cur_end   = 8'h00;
  logic [15:0] cur_max   = MAX_LEN_RESET;

  always #5 clk = ~clk;

  flag_length_frame_extractor_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_index  (out_frame_index),
    .out_frame_last   (out_frame_last),
    .out_frame_status (out_frame_status)
  );

  fle_frame_checker frame_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_index  (out_frame_index),
    .out_frame_last   (out_frame_last),
    .out_frame_status (out_frame_status),
    .errors           (errors),
    .words_due        (words_due)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] byte_other_than(input logic [7:0] x);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == x);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted word is out and the pipe is empty
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [7:0] sf, input logic [7:0] ef,
                           input logic [15:0] ml);
    quiesce();
    write_reg(CFG_START_FLAG, {8'($urandom_range(0, 255)), sf});
    write_reg(CFG_END_FLAG, {8'($urandom_range(0, 255)), ef});
    write_reg(CFG_MAX_LEN, ml);
    cur_start = sf;
    cur_end   = ef;
    cur_max   = ml;
  endtask

  task automatic send_short_frame();
    send_byte(cur_start);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(cur_end);
    phase_words += 4;
  endtask

  task automatic send_frame();
    int          kind;
    int          lim;
    logic [15:0] len;
    kind = $urandom_range(0, 99);
    lim  = (cur_max < MAX_TEST_LEN) ? int'(cur_max) : MAX_TEST_LEN;
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(byte_other_than(cur_start));
    end else if (kind < 23 || lim < int'(MIN_LONG_LEN)) begin
      send_short_frame();
    end else if (kind < 33) begin
      if (cur_max != 16'hFFFF && $urandom_range(0, 1) == 1) begin
        len = ($urandom_range(0, 2) == 0) ? cur_max + 16'd1 :
              16'($urandom_range(int'(cur_max) + 1, 65535));
      end else begin
        len = 16'($urandom_range(0, 4));
      end
      send_byte(cur_start);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(byte_other_than(cur_end));
      phase_words += 4;
    end else begin
      len = ($urandom_range(0, 3) == 0) ? 16'(lim) :
            16'($urandom_range(int'(MIN_LONG_LEN), lim));
      send_byte(cur_start);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(byte_other_than(cur_end));
      for (int i = 4; i < int'(len) - 1; i++) begin
        send_byte(($urandom_range(0, 7) == 0) ? cur_end : 8'($urandom_range(0, 255)));
      end
      // missing end flag on the last word when kind >= 88
      send_byte((kind >= 88) ? byte_other_than(cur_end) : cur_end);
      phase_words += int'(len);
    end
  endtask

  initial begin
    logic [7:0] sf;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: start and end flag are the same value
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);

    apply_cfg(8'h7E, 8'h7F, 16'd8);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_byte(8'h55);
    // early end flag is payload
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h06);
    send_byte(8'hA1); send_byte(8'h7F); send_byte(8'h7F);
    // short frame despite a huge declared length
    send_byte(8'h7E); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
    // length above max, then below minimum
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h09); send_byte(8'h33);
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h04); send_byte(8'h33);
    // missing end flag; closing word equals the start flag
    send_byte(8'h7E); send_byte(8'h00); send_byte(8'h05);
    send_byte(8'h01); send_byte(8'h7E); send_byte(8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      sf = 8'($urandom_range(0, 255));
      case (p)
        0: apply_cfg(8'h7E, 8'h7F, 16'd40);
        1: apply_cfg(8'hFF, 8'h00, 16'hFFFF);
        2: apply_cfg(8'h00, 8'hFF, 16'd4);
        3: apply_cfg(8'hA5, 8'hA5, 16'd20);
        4: begin
          apply_cfg(8'h10, 8'h20, 16'd0);
          write_reg(CFG_UNUSED_IDX, 16'h0000);
        end
        5: apply_cfg(sf, 8'($urandom_range(0, 255)), 16'($urandom_range(5, 40)));
        6: apply_cfg(sf, 8'($urandom_range(0, 255)), MAX_LEN_RESET);
        default: apply_cfg(sf, sf, 16'hFFFF);
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        send_frame();
        if (p == 1 && phase_words >= PHASE_WORDS / 2 && phase_words < PHASE_WORDS / 2 + 5) begin
          quiesce();
        end
      end
    end

    quiesce();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
